### hdl/pfc16_pkg.sv
// Package for the packet framer with CRC-16 trailer.
// Holds the emit phase type, byte kind codes, framing constants and the CRC byte update.
// No dependencies.
package pfc16_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int HDR_LEN_BITS        = 24;

   localparam logic [15:0] CRC_POLY     = 16'h1021;
   // Direct-form seed equal to 0xFFFF followed by a 16-bit zero flush
   localparam logic [15:0] CRC_INIT_DIR = 16'h1D0F;

   localparam logic [7:0] TRAILER_0 = 8'd55;
   localparam logic [7:0] TRAILER_1 = 8'd66;
   localparam logic [7:0] TRAILER_2 = 8'd77;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_CRC     = 2'd2;
   localparam logic [1:0] KIND_TRAILER = 2'd3;

   typedef enum logic [3:0] {
      PH_LEN0,
      PH_LEN1,
      PH_LEN2,
      PH_ID,
      PH_DATA,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_TR0,
      PH_TR1,
      PH_TR2
   } phase_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ data[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

endpackage

### hdl/packet_framer_crc16.sv
// Packet framer: header, payload pass-through, CRC-16 and trailer, one byte per transfer.
// Depends on pfc16_pkg for the phase type, kind codes, constants and CRC update.
//
// Usage:
//   req_* carries one payload byte per transfer; packet_id and payload_length are
//   read with the first byte of a packet, last_byte closes the packet.
//   rsp_* carries one frame byte per transfer with its kind, end_of_frame on the
//   final trailer byte and length_mismatch beside it.
//   A held item register feeds a registered output stage; while the output is free,
//   one frame byte is formed per cycle, and the running CRC advances by one byte
//   for each header and payload byte. An item's frame bytes pass through the held
//   item register and then the output register. A plain payload byte yields one frame
//   byte; a first byte adds the header before it, a last byte adds the CRC and trailer
//   after it, and a byte that is both adds all. All frame bytes share the single output port.
//   req_ready falls while an item still has frame bytes to emit.
//   When rsp_ready is low while the output register holds a byte, it holds, and the held item waits.
//   Reset clears both registers' valid flags, closes any open packet and
//   reloads the CRC seed.
module packet_framer_crc16 #(
   parameter int LENGTH_BITS = pfc16_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   input  logic [7:0]  req_packet_id,
   input  logic [15:0] req_payload_length,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic [1:0]  rsp_byte_kind,
   output logic        rsp_end_of_frame,
   output logic        rsp_length_mismatch
);

   localparam int HL = pfc16_pkg::HDR_LEN_BITS;
   localparam logic [HL-1:0] LenMask =
      (LENGTH_BITS >= HL) ? {HL{1'b1}} : ((HL'(1) << LENGTH_BITS) - HL'(1));

   // held item
   logic                   hold_valid_ff, hold_valid_in;
   logic [7:0]             hold_byte_ff;
   logic [7:0]             hold_id_ff;
   logic [15:0]            hold_len_ff;
   logic                   hold_last_ff;
   pfc16_pkg::phase_type   phase_ff, phase_in, phase_next;

   // packet state
   logic                   in_packet_ff, in_packet_in;
   logic [15:0]            crc_ff, crc_in;
   logic [LENGTH_BITS:0]   count_ff, count_in;
   logic [LENGTH_BITS-1:0] decl_ff, decl_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff;
   logic [1:0]             rsp_kind_ff;
   logic                   rsp_eof_ff;
   logic                   rsp_mis_ff;

   logic                   out_free;
   logic                   emit;
   logic                   done;
   logic                   crc_take;
   logic [7:0]             emit_byte;
   logic [1:0]             emit_kind;
   logic                   emit_eof;
   logic                   emit_mis;
   logic [HL-1:0]          len_masked;
   logic                   accept;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit       = hold_valid_ff && out_free;
   assign req_ready  = !hold_valid_ff || (emit && done);
   assign accept     = req_valid && req_ready;
   assign len_masked = {{(HL-16){1'b0}}, hold_len_ff} & LenMask;

   // next phase
   always_comb begin
      unique case (phase_ff)
         pfc16_pkg::PH_LEN0:   phase_next = pfc16_pkg::PH_LEN1;
         pfc16_pkg::PH_LEN1:   phase_next = pfc16_pkg::PH_LEN2;
         pfc16_pkg::PH_LEN2:   phase_next = pfc16_pkg::PH_ID;
         pfc16_pkg::PH_ID:     phase_next = pfc16_pkg::PH_DATA;
         pfc16_pkg::PH_DATA:   phase_next = pfc16_pkg::PH_CRC_HI;
         pfc16_pkg::PH_CRC_HI: phase_next = pfc16_pkg::PH_CRC_LO;
         pfc16_pkg::PH_CRC_LO: phase_next = pfc16_pkg::PH_TR0;
         pfc16_pkg::PH_TR0:    phase_next = pfc16_pkg::PH_TR1;
         pfc16_pkg::PH_TR1:    phase_next = pfc16_pkg::PH_TR2;
         pfc16_pkg::PH_TR2:    phase_next = pfc16_pkg::PH_LEN0;
         default:              phase_next = pfc16_pkg::PH_LEN0;
      endcase
      if (!hold_valid_ff || (emit && done)) begin
         phase_in = in_packet_in ? pfc16_pkg::PH_DATA : pfc16_pkg::PH_LEN0;
      end else if (emit) begin
         phase_in = phase_next;
      end else begin
         phase_in = phase_ff;
      end
   end

   // frame byte for the current phase
   always_comb begin
      emit_byte = hold_byte_ff;
      emit_kind = pfc16_pkg::KIND_HEADER;
      emit_eof  = 1'b0;
      emit_mis  = 1'b0;
      crc_take  = 1'b0;
      done      = 1'b0;
      unique case (phase_ff)
         pfc16_pkg::PH_LEN0: begin
            emit_byte = len_masked[7:0];
            crc_take  = 1'b1;
         end
         pfc16_pkg::PH_LEN1: begin
            emit_byte = len_masked[15:8];
            crc_take  = 1'b1;
         end
         pfc16_pkg::PH_LEN2: begin
            emit_byte = len_masked[23:16];
            crc_take  = 1'b1;
         end
         pfc16_pkg::PH_ID: begin
            emit_byte = hold_id_ff;
            crc_take  = 1'b1;
         end
         pfc16_pkg::PH_DATA: begin
            emit_byte = hold_byte_ff;
            emit_kind = pfc16_pkg::KIND_PAYLOAD;
            crc_take  = 1'b1;
            done      = !hold_last_ff;
         end
         pfc16_pkg::PH_CRC_HI: begin
            emit_byte = crc_ff[15:8];
            emit_kind = pfc16_pkg::KIND_CRC;
         end
         pfc16_pkg::PH_CRC_LO: begin
            emit_byte = crc_ff[7:0];
            emit_kind = pfc16_pkg::KIND_CRC;
         end
         pfc16_pkg::PH_TR0: begin
            emit_byte = pfc16_pkg::TRAILER_0;
            emit_kind = pfc16_pkg::KIND_TRAILER;
         end
         pfc16_pkg::PH_TR1: begin
            emit_byte = pfc16_pkg::TRAILER_1;
            emit_kind = pfc16_pkg::KIND_TRAILER;
         end
         pfc16_pkg::PH_TR2: begin
            emit_byte = pfc16_pkg::TRAILER_2;
            emit_kind = pfc16_pkg::KIND_TRAILER;
            emit_eof  = 1'b1;
            emit_mis  = (count_ff != {1'b0, decl_ff});
            done      = 1'b1;
         end
         default: begin
            emit_byte = hold_byte_ff;
         end
      endcase
   end

   // packet state and handshake flags
   always_comb begin
      in_packet_in  = in_packet_ff;
      crc_in        = crc_ff;
      count_in      = count_ff;
      decl_in       = decl_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (crc_take) begin
            crc_in = pfc16_pkg::crc_update(crc_ff, emit_byte);
         end
         if (phase_ff == pfc16_pkg::PH_LEN0) begin
            in_packet_in = 1'b1;
            count_in     = '0;
            decl_in      = len_masked[LENGTH_BITS-1:0];
         end
         if (phase_ff == pfc16_pkg::PH_DATA && !count_ff[LENGTH_BITS]) begin
            count_in = count_ff + 1'b1;
         end
         if (phase_ff == pfc16_pkg::PH_TR2) begin
            in_packet_in = 1'b0;
            crc_in       = pfc16_pkg::CRC_INIT_DIR;
            count_in     = '0;
            decl_in      = '0;
         end
         if (done) begin
            hold_valid_in = 1'b0;
         end
      end
      if (accept) begin
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= pfc16_pkg::PH_LEN0;
         in_packet_ff  <= 1'b0;
         crc_ff        <= pfc16_pkg::CRC_INIT_DIR;
         count_ff      <= '0;
         decl_ff       <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         in_packet_ff  <= in_packet_in;
         crc_ff        <= crc_in;
         count_ff      <= count_in;
         decl_ff       <= decl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_byte_ff <= req_payload_byte;
         hold_id_ff   <= req_packet_id;
         hold_len_ff  <= req_payload_length;
         hold_last_ff <= req_last_byte;
      end
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_kind_ff <= emit_kind;
         rsp_eof_ff  <= emit_eof;
         rsp_mis_ff  <= emit_mis;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_byte      = rsp_byte_ff;
   assign rsp_byte_kind       = rsp_kind_ff;
   assign rsp_end_of_frame    = rsp_eof_ff;
   assign rsp_length_mismatch = rsp_mis_ff;

endmodule

### test/packet_framer_crc16_tb.sv
// Testbench for packet_framer_crc16: random and directed packets with a self-checking scoreboard.
// The scoreboard predicts the header, payload, CRC-16 and trailer bytes of every packet.
// Depends on pfc16_pkg and the packet_framer_crc16 RTL.
`timescale 1ns / 100ps

typedef struct packed {
   logic [7:0] data;
   logic [1:0] kind;
   logic       eof;
   logic       mismatch;
} frame_beat_type;

class frame_scoreboard;
   frame_beat_type expected_beats[$];
   logic [15:0] crc;
   bit          pkt_open;
   logic [16:0] byte_count;
   logic [15:0] declared_len;
   int          errors;

   function new();
      errors = 0;
      close_packet();
   endfunction

   function void close_packet();
      crc          = 16'hFFFF;
      pkt_open     = 0;
      byte_count   = '0;
      declared_len = '0;
   endfunction

   function logic [15:0] crc_shift(logic [15:0] c, logic [7:0] d);
      logic carry;
      for (int i = 7; i >= 0; i--) begin
         carry = c[15];
         c     = {c[14:0], d[i]};
         if (carry) begin
            c = c ^ pfc16_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   function void push_beat(logic [7:0] data, logic [1:0] kind, logic eof, logic mismatch);
      frame_beat_type beat;
      beat.data     = data;
      beat.kind     = kind;
      beat.eof      = eof;
      beat.mismatch = mismatch;
      expected_beats.push_back(beat);
   endfunction

   function void add_framed(logic [7:0] data, logic [1:0] kind);
      crc = crc_shift(crc, data);
      push_beat(data, kind, 1'b0, 1'b0);
   endfunction

   function void predict_frame_bytes(logic [7:0] data, logic [7:0] id, logic [15:0] len,
                                     logic last);
      logic [15:0] flushed;
      logic        mismatch;
      if (!pkt_open) begin
         pkt_open     = 1;
         crc          = 16'hFFFF;
         byte_count   = '0;
         declared_len = len;
         add_framed(len[7:0], pfc16_pkg::KIND_HEADER);
         add_framed(len[15:8], pfc16_pkg::KIND_HEADER);
         add_framed(8'h00, pfc16_pkg::KIND_HEADER);
         add_framed(id, pfc16_pkg::KIND_HEADER);
      end
      add_framed(data, pfc16_pkg::KIND_PAYLOAD);
      if (byte_count < 17'h10000) begin
         byte_count = byte_count + 1'b1;
      end
      if (last) begin
         flushed  = crc_shift(crc_shift(crc, 8'h00), 8'h00);
         mismatch = (byte_count != {1'b0, declared_len});
         push_beat(flushed[15:8], pfc16_pkg::KIND_CRC, 1'b0, 1'b0);
         push_beat(flushed[7:0], pfc16_pkg::KIND_CRC, 1'b0, 1'b0);
         push_beat(pfc16_pkg::TRAILER_0, pfc16_pkg::KIND_TRAILER, 1'b0, 1'b0);
         push_beat(pfc16_pkg::TRAILER_1, pfc16_pkg::KIND_TRAILER, 1'b0, 1'b0);
         push_beat(pfc16_pkg::TRAILER_2, pfc16_pkg::KIND_TRAILER, 1'b1, mismatch);
         close_packet();
      end
   endfunction

   function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $error("%s expected %0d got %0d", field, want, got);
   endfunction

   function void check_frame_byte(logic [7:0] data, logic [1:0] kind, logic eof,
                                  logic mismatch);
      frame_beat_type want;
      if (expected_beats.size() == 0) begin
         errors++;
         $error("frame_byte expected none got %0d", data);
      end else begin
         want = expected_beats.pop_front();
         if (data !== want.data) report("frame_byte", want.data, data);
         if (kind !== want.kind) report("byte_kind", want.kind, kind);
         if (eof !== want.eof) report("end_of_frame", want.eof, eof);
         if (mismatch !== want.mismatch) report("length_mismatch", want.mismatch, mismatch);
      end
   endfunction

   function int pending();
      return expected_beats.size();
   endfunction
endclass

module packet_framer_crc16_tb;
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [7:0]  req_payload_byte    = '0;
   logic [7:0]  req_packet_id       = '0;
   logic [15:0] req_payload_length  = '0;
   logic        req_last_byte       = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic [1:0]  rsp_byte_kind;
   logic        rsp_end_of_frame;
   logic        rsp_length_mismatch;

   frame_scoreboard sb;
   bit              quiet = 0;
   int              items_sent = 0;
   int              cycle_count = 0;

   packet_framer_crc16 u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_payload_byte    (req_payload_byte),
      .req_packet_id       (req_packet_id),
      .req_payload_length  (req_payload_length),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_byte_kind       (rsp_byte_kind),
      .rsp_end_of_frame    (rsp_end_of_frame),
      .rsp_length_mismatch (rsp_length_mismatch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] data, logic [7:0] id, logic [15:0] len, logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_payload_byte   <= data;
      req_packet_id      <= id;
      req_payload_length <= len;
      req_last_byte      <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.predict_frame_bytes(data, id, len, last);
      items_sent++;
   endtask

   task automatic send_packet(int count, logic [15:0] declared, logic [7:0] id);
      for (int i = 0; i < count; i++) begin
         if (i == 0) begin
            send_byte(8'($urandom_range(0, 255)), id, declared, count == 1);
         end else begin
            send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), i == count - 1);
         end
      end
   endtask

   task automatic drain_frames();
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_frame_byte(rsp_frame_byte, rsp_byte_kind, rsp_end_of_frame,
                             rsp_length_mismatch);
      end
   endtask

   initial begin
      int          count;
      logic [15:0] declared;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_frames();
      join_none

      // single-byte packets: zero id, max length, zero length
      send_byte(8'h00, 8'h00, 16'd1, 1'b1);
      send_byte(8'hFF, 8'hFF, 16'hFFFF, 1'b1);
      send_byte(8'hA5, 8'h5A, 16'd0, 1'b1);
      send_byte(8'h3C, 8'h01, 16'h0100, 1'b1);
      // matched, short and overlong packets
      send_byte(8'h00, 8'h80, 16'd3, 1'b0);
      send_byte(8'hFF, 8'h00, 16'hFFFF, 1'b0);
      send_byte(8'h80, 8'hFF, 16'h0000, 1'b1);
      send_byte(8'h01, 8'h7F, 16'd5, 1'b0);
      send_byte(8'hFE, 8'h00, 16'd1, 1'b1);
      send_byte(8'h55, 8'hAA, 16'd3, 1'b0);
      send_byte(8'hAA, 8'h55, 16'd3, 1'b0);
      send_byte(8'h0F, 8'h33, 16'd7, 1'b0);
      send_byte(8'hF0, 8'hCC, 16'd9, 1'b1);

      while (items_sent < 295) begin
         quiet = ($urandom_range(0, 3) == 0);
         count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         case ($urandom_range(0, 9))
            0: declared = 16'(count + 1);
            1: declared = 16'(count - 1);
            2: declared = 16'd0;
            3: declared = 16'($urandom_range(0, 65535));
            default: declared = 16'(count);
         endcase
         send_packet(count, declared, 8'($urandom_range(0, 255)));
      end

      send_packet(3, 16'd3, 8'h44);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
